// ----- rtl/ftu_pkg.sv -----
// Shared types, constants and calendar tables for the FAT timestamp converter.
package ftu_pkg;

   localparam int DATE_W = 16;
   localparam int TIME_W = 16;
   localparam int SECS_W = 31;
   localparam int TZ_W   = 12;
   localparam int DAYS_W = 16;
   localparam int TOD_W  = 17;
   localparam int ADJ_W  = 18;
   localparam int SUM_W  = 33;

   localparam logic [SECS_W-1:0] SAT_MAX   = 31'h7fff_ffff;
   // Largest whole day count and remaining seconds that still fit below SAT_MAX.
   localparam logic [DAYS_W-1:0] DAY_LIMIT = 16'd24855;
   localparam logic [TOD_W-1:0]  TOD_LIMIT = 17'd11647;

   localparam logic signed [TZ_W-1:0] TZ_MAX = 12'sd1440;
   localparam logic signed [TZ_W-1:0] TZ_MIN = -12'sd1440;

   // Year offsets from 1980 that touch the 2100 century rule.
   localparam logic [6:0] YEAR_2100      = 7'd120;
   localparam logic [6:0] YEAR_2100_NEXT = 7'd121;

   // Register index of the zone offset on the configuration port.
   localparam logic REG_TZ = 1'b0;

   typedef struct packed {
      logic load;
      logic decode;
      logic scale;
      logic adjust;
   } ftu_cmd_type;

   function automatic logic [4:0] month_len(input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // Days in a common year before the first of the month.
   function automatic logic [8:0] month_start(input logic [3:0] month);
      logic [8:0] start_day;
      case (month)
         4'd1:    start_day = 9'd0;
         4'd2:    start_day = 9'd31;
         4'd3:    start_day = 9'd59;
         4'd4:    start_day = 9'd90;
         4'd5:    start_day = 9'd120;
         4'd6:    start_day = 9'd151;
         4'd7:    start_day = 9'd181;
         4'd8:    start_day = 9'd212;
         4'd9:    start_day = 9'd243;
         4'd10:   start_day = 9'd273;
         4'd11:   start_day = 9'd304;
         4'd12:   start_day = 9'd334;
         default: start_day = 9'd0;
      endcase
      return start_day;
   endfunction

endpackage

// ----- rtl/ftu_ctrl.sv -----
// Sequencer that steps one conversion through decode, scale and zone adjust.
module ftu_ctrl
   import ftu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output ftu_cmd_type cmd,
   output logic        rsp_strobe
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECODE = 4'b0010,
      ST_SCALE  = 4'b0100,
      ST_ADJUST = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in   = state_ff;
      strobe_in  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_ADJUST;
         end
         ST_ADJUST: begin
            cmd.adjust = 1'b1;
            strobe_in  = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// ----- rtl/ftu_datapath.sv -----
// Field decode, day count, scaling to seconds, and zone adjust with clamping.
module ftu_datapath
   import ftu_pkg::*;
(
   input  logic                     clock,
   input  ftu_cmd_type              cmd,
   input  logic [DATE_W-1:0]        req_dos_date,
   input  logic [TIME_W-1:0]        req_dos_time,
   input  logic signed [TZ_W-1:0]   tz_minutes_west,
   output logic [SECS_W-1:0]        rsp_unix_seconds
);

   logic [DATE_W-1:0] date_ff;
   logic [TIME_W-1:0] time_ff;

   logic [6:0] year_off;
   logic [3:0] month;
   logic [4:0] day;
   logic [4:0] hour;
   logic [5:0] minute;
   logic [4:0] sec_half;
   logic       leap;
   logic       leap_bump;
   logic [4:0] day_limit;
   logic [5:0] leap_cnt;
   logic [7:0] year_plus3;
   logic [DAYS_W-1:0] year_days;

   logic              valid_ff, valid_in;
   logic [DAYS_W-1:0] days_ff, days_in;
   logic [TOD_W-1:0]  tod_ff, tod_in;

   logic [SUM_W-1:0]        product;
   logic                    tz_ok;
   logic signed [ADJ_W-1:0] tz_ext;
   logic                    sat_ff, sat_in;
   logic [SECS_W-1:0]       total_ff, total_in;
   logic signed [ADJ_W-1:0] adj_ff, adj_in;

   logic signed [SUM_W-1:0] sum_s;
   logic [SECS_W-1:0]       result_ff, result_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         date_ff <= req_dos_date;
         time_ff <= req_dos_time;
      end
   end

   // Decode: check fields and count days since 1970.
   always_comb begin
      year_off  = date_ff[15:9];
      month     = date_ff[8:5];
      day       = date_ff[4:0];
      hour      = time_ff[15:11];
      minute    = time_ff[10:5];
      sec_half  = time_ff[4:0];

      // 1980 is a leap year, so the offset's low bits follow the four-year rule.
      leap      = (year_off[1:0] == 2'b00) && (year_off != YEAR_2100);
      leap_bump = leap && (month > 4'd2);
      day_limit = month_len(month) + {4'd0, (month == 4'd2) && leap};

      valid_in  = (month != 4'd0) && (month <= 4'd12) && (day != 5'd0) &&
                  (hour <= 5'd23) && (minute <= 6'd59) && (sec_half <= 5'd29) &&
                  (day <= day_limit);

      // Leap days between 1970 and the start of the year: 1972 and 1976 plus
      // one per four years from 1980, less one once 2100 has passed.
      year_plus3 = {1'b0, year_off} + 8'd3;
      leap_cnt   = 6'd2 + year_plus3[7:2] -
                   {5'd0, (year_off >= YEAR_2100_NEXT)};
      year_days  = ({9'd0, year_off} + DAYS_W'(10)) * DAYS_W'(365) +
                   DAYS_W'(leap_cnt);

      days_in = year_days + DAYS_W'(month_start(month)) + DAYS_W'(leap_bump) +
                DAYS_W'(day) - DAYS_W'(1);
      tod_in  = TOD_W'(hour) * TOD_W'(3600) + TOD_W'(minute) * TOD_W'(60) +
                TOD_W'({sec_half, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         valid_ff <= valid_in;
         days_ff  <= days_in;
         tod_ff   <= tod_in;
      end
   end

   // Scale: days to seconds, saturation check, zone offset to seconds.
   always_comb begin
      sat_in   = (days_ff > DAY_LIMIT) ||
                 ((days_ff == DAY_LIMIT) && (tod_ff > TOD_LIMIT));
      product  = SUM_W'(days_ff) * SUM_W'(86400) + SUM_W'(tod_ff);
      total_in = product[SECS_W-1:0];
      tz_ok    = (tz_minutes_west >= TZ_MIN) && (tz_minutes_west <= TZ_MAX);
      tz_ext   = {{(ADJ_W-TZ_W){tz_minutes_west[TZ_W-1]}}, tz_minutes_west};
      adj_in   = tz_ok ? (tz_ext * 18'sd60) : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         sat_ff   <= sat_in;
         total_ff <= total_in;
         adj_ff   <= adj_in;
      end
   end

   // Adjust: apply the offset, then clamp to the unsigned 31-bit range; invalid fields give 0.
   always_comb begin
      sum_s = $signed({2'b00, total_ff}) +
              $signed({{(SUM_W-ADJ_W){adj_ff[ADJ_W-1]}}, adj_ff});
      if (!valid_ff) begin
         result_in = '0;
      end else if (sat_ff) begin
         result_in = SAT_MAX;
      end else if (sum_s[SUM_W-1]) begin
         result_in = '0;
      end else if (sum_s[SUM_W-2:SECS_W] != '0) begin
         result_in = SAT_MAX;
      end else begin
         result_in = sum_s[SECS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.adjust) begin
         result_ff <= result_in;
      end
   end

   assign rsp_unix_seconds = result_ff;

endmodule

// ----- rtl/fat_timestamp_to_unix_seconds_unit.sv -----
// Top level of the FAT date/time to Unix seconds converter with its zone register.
//
//   channel   ports                                       transfer when
//   request   start, busy, req_dos_date, req_dos_time     start high, busy low
//   result    rsp_strobe, rsp_unix_seconds                rsp_strobe high
//   config    psel, penable, pwrite, paddr, pwdata, ...   psel, penable, pwrite, pready
//
// Each conversion runs the request transfer, then decode, scale and adjust in
// that order, stepped by the controller's state machine.
// A new request may transfer in the cycle the result strobe is high.
// Reset is synchronous and returns the controller to idle and the zone offset to 0.
// The result strobe is high for one cycle only; the receiver cannot stall it.
module fat_timestamp_to_unix_seconds_unit
   import ftu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [DATE_W-1:0]  req_dos_date,
   input  logic [TIME_W-1:0]  req_dos_time,
   output logic               rsp_strobe,
   output logic [SECS_W-1:0]  rsp_unix_seconds,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   ftu_cmd_type           cmd;
   logic signed [TZ_W-1:0] tz_ff;
   logic                   csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff <= '0;
      end else if (csr_write && (paddr[2] == REG_TZ)) begin
         tz_ff <= pwdata[TZ_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_TZ) ? {{(32-TZ_W){tz_ff[TZ_W-1]}}, tz_ff} : '0;

   ftu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   ftu_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .req_dos_date     (req_dos_date),
      .req_dos_time     (req_dos_time),
      .tz_minutes_west  (tz_ff),
      .rsp_unix_seconds (rsp_unix_seconds)
   );

endmodule
